### hw/rtl/hmbs_pkg.sv
// ----------------------------------------------------------------------------
// hmbs_pkg: shared types and constants for the heightmap bilinear sampler
// Field widths, register map, parameter defaults and the blend unit's
// control word.
// ----------------------------------------------------------------------------
`default_nettype none

package hmbs_pkg;

  // Parameter defaults
  localparam int MAX_COLS_DEF  = 64;
  localparam int MAX_ROWS_DEF  = 64;
  localparam int FRAC_BITS_DEF = 8;

  // Fixed field widths
  localparam int MAP_W    = 7;
  localparam int COL_W    = 6;
  localparam int ROW_W    = 6;
  localparam int SAMPLE_W = 16;
  localparam int COORD_W  = 14;
  localparam int HEIGHT_W = 16;
  localparam int PDATA_W  = 32;
  localparam int PADDR_W  = 3;

  // Item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Register indexes (paddr[2])
  localparam logic REG_MAP_WIDTH  = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  // Accumulator operation of the blend unit
  typedef enum logic [1:0] {
    ACC_HOLD = 2'b00,
    ACC_LOAD = 2'b01,
    ACC_ADD  = 2'b10
  } acc_op_t;

  typedef struct packed {
    acc_op_t acc_op;
    logic    save_t;
  } mac_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/heightmap_bilinear_sampler_core.sv
// Sequence: a write word is stored as it is accepted; a query passes through a bounds
//   check, 4 corner reads on the one read port, 6 products on the shared
//   multiplier, a result load and a return to idle (out of range: check, then load).
// No new word is accepted until the query is back in idle, and the result load waits
//   for a free result register.
// Reset (rst_n low, synchronous): idle, no result pending, both map registers 64.
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler_core: bilinear heightmap sampler
// Keeps a grid of signed Q8.8 heights and returns the rounded bilinear blend
// of the four corners around a fixed-point query position. The height store
// is not cleared at reset; read only entries that were written.
// ----------------------------------------------------------------------------
`default_nettype none

module heightmap_bilinear_sampler_core #(
  parameter int MAX_COLS  = hmbs_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS  = hmbs_pkg::MAX_ROWS_DEF,
  parameter int FRAC_BITS = hmbs_pkg::FRAC_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // input words
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire                                  in_mode,
  input  wire         [hmbs_pkg::COL_W-1:0]    in_write_col,
  input  wire         [hmbs_pkg::ROW_W-1:0]    in_write_row,
  input  wire  signed [hmbs_pkg::SAMPLE_W-1:0] in_sample,
  input  wire         [hmbs_pkg::COORD_W-1:0]  in_coord_x,
  input  wire         [hmbs_pkg::COORD_W-1:0]  in_coord_z,
  // result words
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic signed [hmbs_pkg::HEIGHT_W-1:0] out_height,
  output logic                                 out_out_of_range,
  // configuration
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire         [hmbs_pkg::PADDR_W-1:0]  paddr,
  input  wire         [hmbs_pkg::PDATA_W-1:0]  pwdata,
  output logic        [hmbs_pkg::PDATA_W-1:0]  prdata,
  output logic                                 pready
);

  import hmbs_pkg::*;

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = FRAC_BITS + 1;          // corner weight, 0..1.0
  localparam int TW    = FRAC_BITS + 18;         // row sum
  localparam int ACW   = 2 * FRAC_BITS + 21;     // accumulator
  localparam int CXW   = COORD_W + FRAC_BITS;    // coordinate, padded
  localparam int BW    = 16;                     // bounds compare width

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_READ   = 5'b00100,
    S_MAC    = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  // Map registers
  logic [MAP_W-1:0] map_width_r, map_width_nxt;
  logic [MAP_W-1:0] map_height_r, map_height_nxt;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    map_width_nxt  = map_width_r;
    map_height_nxt = map_height_r;
    if (cfg_wr) begin
      case (paddr[2])
        REG_MAP_WIDTH:  map_width_nxt  = pwdata[MAP_W-1:0];
        REG_MAP_HEIGHT: map_height_nxt = pwdata[MAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MAP_WIDTH:  prdata = {{(PDATA_W-MAP_W){1'b0}}, map_width_r};
      REG_MAP_HEIGHT: prdata = {{(PDATA_W-MAP_W){1'b0}}, map_height_r};
      default:        prdata = '0;
    endcase
  end

  // Input acceptance and the sample write path
  logic        in_acc;
  logic        wr_en;
  logic [31:0] wr_idx;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid & in_ready;
  assign wr_idx   = 32'(in_write_row) * 32'(MAX_COLS) + 32'(in_write_col);
  assign wr_en    = in_acc && (in_mode == MODE_WRITE) &&
                    (32'(in_write_col) < 32'(MAX_COLS)) &&
                    (32'(in_write_row) < 32'(MAX_ROWS));

  // Query coordinates: integer part picks the cell, fraction weights it
  logic [COORD_W-1:0]   cx_r, cz_r;
  logic [CXW-1:0]       cx_ext, cz_ext;
  logic [FRAC_BITS-1:0] fx, fz;
  logic [COORD_W-1:0]   x0, z0;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cx_r <= in_coord_x;
      cz_r <= in_coord_z;
    end
  end

  assign cx_ext = {{FRAC_BITS{1'b0}}, cx_r};
  assign cz_ext = {{FRAC_BITS{1'b0}}, cz_r};
  assign fx     = cx_ext[FRAC_BITS-1:0];
  assign fz     = cz_ext[FRAC_BITS-1:0];
  assign x0     = cx_ext[CXW-1:FRAC_BITS];
  assign z0     = cz_ext[CXW-1:FRAC_BITS];

  // Bounds check: clamp the map registers to the store size, then test
  // the far corner of the cell
  logic [BW-1:0] w_eff, h_eff;
  logic          oor;

  always_comb begin
    w_eff = (BW'(map_width_r) > BW'(MAX_COLS))  ? BW'(MAX_COLS) : BW'(map_width_r);
    h_eff = (BW'(map_height_r) > BW'(MAX_ROWS)) ? BW'(MAX_ROWS) : BW'(map_height_r);
    oor   = (BW'(x0) + BW'(1) >= w_eff) || (BW'(z0) + BW'(1) >= h_eff);
  end

  // Corner address generation
  logic [31:0]   base_idx;
  logic [AW-1:0] base_r;
  logic [AW-1:0] rd_addr;
  logic          oor_r;

  assign base_idx = 32'(z0) * 32'(MAX_COLS) + 32'(x0);

  always_ff @(posedge clk) begin
    if (state_r == S_CHECK) begin
      base_r <= base_idx[AW-1:0];
      oor_r  <= oor;
    end
  end

  // Corner order: q11, q12 (next row), q21 (next column), q22
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    rd_addr = base_r;
      2'd1:    rd_addr = base_r + AW'(MAX_COLS);
      2'd2:    rd_addr = base_r + AW'(1);
      default: rd_addr = base_r + AW'(MAX_COLS + 1);
    endcase
  end

  logic [SAMPLE_W-1:0] rd_data;

  hmbs_store #(
    .DEPTH  (DEPTH),
    .DATA_W (SAMPLE_W)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx[AW-1:0]),
    .wdata (in_sample),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Shift the corners in as they come back; after four reads entry 0 is q11
  logic signed [SAMPLE_W-1:0] corner_r [4];

  always_ff @(posedge clk) begin
    if ((state_r == S_READ) && (cnt_r != 3'd0)) begin
      corner_r[3] <= rd_data;
      corner_r[2] <= corner_r[3];
      corner_r[1] <= corner_r[2];
      corner_r[0] <= corner_r[1];
    end
  end

  // Blend schedule on the shared multiplier:
  //   steps 0..3 form the two row sums along z, steps 4..5 blend them along x.
  //   The product is registered, so the accumulate runs a step behind.
  logic [WW-1:0]          wx0, wx1, wz0, wz1;
  logic [WW-1:0]          mac_w;
  logic signed [TW-1:0]   mac_b;
  logic signed [ACW-1:0]  mac_acc;
  logic signed [TW-1:0]   mac_t;
  mac_ctl_t               mac_ctl;

  assign wx1 = {1'b0, fx};
  assign wz1 = {1'b0, fz};
  assign wx0 = (WW'(1) << FRAC_BITS) - wx1;
  assign wz0 = (WW'(1) << FRAC_BITS) - wz1;

  always_comb begin
    mac_w = wz0;
    mac_b = TW'(corner_r[0]);
    case (cnt_r)
      3'd0: begin
        mac_w = wz0;
        mac_b = TW'(corner_r[0]);
      end
      3'd1: begin
        mac_w = wz1;
        mac_b = TW'(corner_r[1]);
      end
      3'd2: begin
        mac_w = wz0;
        mac_b = TW'(corner_r[2]);
      end
      3'd3: begin
        mac_w = wz1;
        mac_b = TW'(corner_r[3]);
      end
      3'd4: begin
        mac_w = wx0;
        mac_b = mac_t;
      end
      3'd5: begin
        // accumulator holds the second row sum at this step
        mac_w = wx1;
        mac_b = mac_acc[TW-1:0];
      end
      default: begin
        mac_w = wz0;
        mac_b = TW'(corner_r[0]);
      end
    endcase
  end

  always_comb begin
    mac_ctl.acc_op = ACC_HOLD;
    mac_ctl.save_t = 1'b0;
    if (state_r == S_MAC) begin
      case (cnt_r)
        3'd1, 3'd3, 3'd5: mac_ctl.acc_op = ACC_LOAD;
        3'd2: begin
          mac_ctl.acc_op = ACC_ADD;
          mac_ctl.save_t = 1'b1;
        end
        3'd4, 3'd6:       mac_ctl.acc_op = ACC_ADD;
        default:          mac_ctl.acc_op = ACC_HOLD;
      endcase
    end
  end

  hmbs_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk     (clk),
    .ctl     (mac_ctl),
    .weight  (mac_w),
    .operand (mac_b),
    .acc     (mac_acc),
    .t_sum   (mac_t)
  );

  // Round half up: add half an output step, keep the bits above the fraction
  logic signed [ACW-1:0]      rnd;
  logic signed [HEIGHT_W-1:0] height_res;

  assign rnd        = mac_acc + (ACW'(1) << (2 * FRAC_BITS - 1));
  assign height_res = oor_r ? '0 : rnd[2*FRAC_BITS+HEIGHT_W-1:2*FRAC_BITS];

  // Result register: parts the output side from the sequencer
  logic                       out_valid_r, out_valid_nxt;
  logic signed [HEIGHT_W-1:0] out_height_r;
  logic                       out_oor_r;
  logic                       res_load;

  assign res_load = (state_r == S_RESULT) && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_height_r <= height_res;
      out_oor_r    <= oor_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_height       = out_height_r;
  assign out_out_of_range = out_oor_r;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = 3'd0;
        if (in_acc && (in_mode == MODE_QUERY)) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cnt_nxt   = 3'd0;
        state_nxt = oor ? S_RESULT : S_READ;
      end
      S_READ: begin
        // issue reads on counts 0..3, capture on counts 1..4
        if (cnt_r == 3'd4) begin
          cnt_nxt   = 3'd0;
          state_nxt = S_MAC;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_MAC: begin
        if (cnt_r == 3'd6) begin
          cnt_nxt   = 3'd0;
          state_nxt = S_RESULT;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_RESULT: begin
        // hold until the result register is free
        if (res_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        cnt_nxt   = 3'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= 3'd0;
      out_valid_r  <= 1'b0;
      map_width_r  <= MAP_W'(64);
      map_height_r <= MAP_W'(64);
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      map_width_r  <= map_width_nxt;
      map_height_r <= map_height_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/hmbs_store.sv
// ----------------------------------------------------------------------------
// hmbs_store: height sample store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module hmbs_store #(
  parameter int DEPTH  = 4096,
  parameter int DATA_W = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [DATA_W-1:0]        wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/hmbs_mac.sv
// ----------------------------------------------------------------------------
// hmbs_mac: shared multiply-accumulate unit for the bilinear blend
// Registers the product, then loads or adds it into the accumulator;
// can hold the partial row sum aside.
// ----------------------------------------------------------------------------
`default_nettype none

module hmbs_mac #(
  parameter int FRAC_BITS = 8
) (
  input  wire                                      clk,
  input  wire         hmbs_pkg::mac_ctl_t          ctl,
  input  wire         [FRAC_BITS:0]                weight,
  input  wire  signed [FRAC_BITS+17:0]             operand,
  output logic signed [2*FRAC_BITS+20:0]           acc,
  output logic signed [FRAC_BITS+17:0]             t_sum
);

  import hmbs_pkg::*;

  localparam int WW  = FRAC_BITS + 1;
  localparam int TW  = FRAC_BITS + 18;
  localparam int PW  = WW + 1 + TW;
  localparam int ACW = PW + 1;

  logic signed [PW-1:0]  prod_r;
  logic signed [ACW-1:0] prod_ext;
  logic signed [ACW-1:0] acc_r, acc_nxt;
  logic signed [TW-1:0]  t_r, t_nxt;

  always_comb begin
    prod_ext = {prod_r[PW-1], prod_r};
    case (ctl.acc_op)
      ACC_LOAD: acc_nxt = prod_ext;
      ACC_ADD:  acc_nxt = acc_r + prod_ext;
      default:  acc_nxt = acc_r;
    endcase
    t_nxt = ctl.save_t ? acc_nxt[TW-1:0] : t_r;
  end

  always_ff @(posedge clk) begin
    prod_r <= $signed({1'b0, weight}) * operand;
    acc_r  <= acc_nxt;
    t_r    <= t_nxt;
  end

  assign acc   = acc_r;
  assign t_sum = t_r;

endmodule

`default_nettype wire
